### rtl/linear_probe_hash_map_core_macros.svh
// Assertion macros for the hash map core and its checker.
`ifndef LINEAR_PROBE_HASH_MAP_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_MAP_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LPHM_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LPHM_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/lphm_pkg.sv
package lphm_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 11;

    typedef enum logic [1:0] {
        FN_SEARCH = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_HIT  = 3'd0,
        ST_MISS = 3'd1,
        ST_NEW  = 3'd2,
        ST_UPD  = 3'd3,
        ST_REM  = 3'd4,
        ST_FULL = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        WR_CLR_PTR = 2'd0,
        WR_ENTRY   = 2'd1,
        WR_MOVE    = 2'd2
    } wr_mode_t;

    typedef enum logic [1:0] {
        N_HOLD = 2'd0,
        N_ZERO = 2'd1,
        N_ONE  = 2'd2,
        N_INC  = 2'd3
    } n_op_t;

    typedef enum logic [1:0] {
        P_HOLD = 2'd0,
        P_HOME = 2'd1,
        P_NEXT = 2'd2
    } ptr_op_t;

    typedef struct packed {
        logic     capture;
        logic     mod_start;
        logic     mod_sel_row;
        ptr_op_t  ptr_op;
        logic     gap_load;
        n_op_t    n_op;
        logic     rd_en;
        logic     wr_en;
        wr_mode_t wr_mode;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     load_result;
        status_t  res_status;
    } lphm_cmd_t;

    typedef struct packed {
        func_t func;
        logic  mod_done;
        logic  row_used;
        logic  key_match;
        logic  stays;
        logic  ptr_last;
        logic  n_last;
    } lphm_sts_t;

endpackage

### rtl/lphm_if.sv
interface lphm_req_if import lphm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [1:0]              func;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, func, key, value, input ready);
    modport sink (input valid, func, key, value, output ready);
endinterface

interface lphm_rsp_if import lphm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;

    modport source (output valid, status, read_value, entry_count, is_empty, input ready);
    modport sink (input valid, status, read_value, entry_count, is_empty, output ready);
endinterface

### rtl/linear_probe_hash_map_core.sv
// A request is captured, its key's home slot computed, and slots probed in turn from the home
// slot until the key matches, a free slot is found or every slot has been probed.
// Remove: the walk goes on past the freed slot; for each chain entry the home is computed,
// and an entry whose home is not in (gap, slot] is moved back into the gap, which then moves to
// its old slot. A free slot ends the chain. One request is in flight; the next is taken once
// the result is registered. Reset: a clearing pass frees every slot; req.ready stays low.
module linear_probe_hash_map_core import lphm_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    lphm_req_if.sink    req,
    lphm_rsp_if.source  rsp
);

    lphm_cmd_t  cmd;
    lphm_sts_t  sts;

    lphm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lphm_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_func        (req.func),
        .req_key         (req.key),
        .req_value       (req.value),
        .cmd             (cmd),
        .sts             (sts),
        .rsp_status      (rsp.status),
        .rsp_read_value  (rsp.read_value),
        .rsp_entry_count (rsp.entry_count),
        .rsp_is_empty    (rsp.is_empty)
    );

endmodule

### rtl/lphm_mod.sv
// Home slot unit: din modulo CAPACITY. For a power-of-two capacity the low
// bits are registered; otherwise a reciprocal multiply gives a registered
// quotient estimate, then the remainder is formed and corrected by one compare and subtract.
module lphm_mod #(
    parameter int CAPACITY = 1024,
    parameter int KW       = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [KW-1:0]               din,
    output logic                        done,
    output logic [$clog2(CAPACITY)-1:0] rem
);

    localparam int AW = $clog2(CAPACITY);

    generate
        if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_pow2
            logic [AW+KW-1:0] ext;
            logic [AW-1:0]    rem_reg;
            logic             done_reg;

            assign ext = {{AW{1'b0}}, din};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= ext[AW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_recip
            localparam int RW = AW + 1;
            localparam int SH = KW - 1 + AW;
            // floor(2^SH / CAPACITY) fits in KW bits; the quotient estimate is
            // short by at most one, so the raw remainder stays below 2*CAPACITY
            localparam logic [KW-1:0] RECIP = KW'((64'd1 << SH) / CAPACITY);

            logic [2*KW-1:0]    prod;
            logic [2*KW+RW-1:0] quot;
            logic [KW+RW-1:0]   dext;
            logic [RW-1:0]      q_reg;
            logic [RW-1:0]      d_reg;
            logic [2*RW-1:0]    qc;
            logic [RW-1:0]      est;
            logic [RW-1:0]      fix;
            logic [AW-1:0]      rem_reg;
            logic               stage_reg;
            logic               done_reg;

            assign prod = (2*KW)'(din) * (2*KW)'(RECIP);
            assign quot = {{RW{1'b0}}, prod} >> SH;
            assign dext = {{RW{1'b0}}, din};

            // only the low RW bits matter: the true remainder is below 2^RW
            assign qc  = (2*RW)'(q_reg) * (2*RW)'(CAPACITY);
            assign est = d_reg - qc[RW-1:0];
            assign fix = (est >= RW'(CAPACITY)) ? est - RW'(CAPACITY) : est;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end
                else
                begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    q_reg <= quot[RW-1:0];
                    d_reg <= dext[RW-1:0];
                end
                if (stage_reg)
                begin
                    rem_reg <= fix[AW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

### rtl/lphm_dp.sv
module lphm_dp import lphm_pkg::*; #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         req_func,
    input  logic [KEY_W-1:0]   req_key,
    input  logic [VAL_W-1:0]   req_value,
    input  lphm_cmd_t          cmd,
    output lphm_sts_t          sts,
    output logic [2:0]         rsp_status,
    output logic [VAL_W-1:0]   rsp_read_value,
    output logic [COUNT_W-1:0] rsp_entry_count,
    output logic               rsp_is_empty
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW  = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int RWD = 1 + KW + VW;

    // row = {used, key, value}
    logic [RWD-1:0] mem [CAPACITY];

    func_t          func_reg;
    logic [KW-1:0]  key_reg;
    logic [VW-1:0]  val_reg;
    logic [AW-1:0]  ptr_reg;
    logic [AW-1:0]  gap_reg;
    logic [AW-1:0]  n_reg;
    logic [CW-1:0]  count_reg;
    logic [RWD-1:0] q_reg;
    logic [2:0]     status_reg;
    logic [VAL_W-1:0]   rdval_reg;
    logic [COUNT_W-1:0] ecount_reg;
    logic               empty_reg;

    logic           q_used;
    logic [KW-1:0]  q_key;
    logic [VW-1:0]  q_val;
    logic [KW-1:0]  mod_din;
    logic           mod_done;
    logic [AW-1:0]  mod_rem;
    logic           ptr_last;
    logic [AW-1:0]  ptr_step;
    logic           stays;
    logic [AW-1:0]  wr_addr;
    logic [RWD-1:0] wr_data;
    logic [VW+VAL_W-1:0]   val_ext;
    logic [CW+COUNT_W-1:0] cnt_ext;

    assign q_used = q_reg[RWD-1];
    assign q_key  = q_reg[KW+VW-1:VW];
    assign q_val  = q_reg[VW-1:0];

    assign mod_din = cmd.mod_sel_row ? q_key : key_reg;

    lphm_mod #(
        .CAPACITY (CAPACITY),
        .KW       (KW)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mod_start),
        .din   (mod_din),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign ptr_last = (ptr_reg == AW'(CAPACITY - 1));
    assign ptr_step = ptr_last ? '0 : ptr_reg + AW'(1);

    // entry at ptr stays put when its home lies cyclically in (gap, ptr]
    always_comb
    begin
        if (gap_reg <= ptr_reg)
        begin
            stays = (mod_rem > gap_reg) && (mod_rem <= ptr_reg);
        end
        else
        begin
            stays = (mod_rem > gap_reg) || (mod_rem <= ptr_reg);
        end
    end

    always_comb
    begin
        case (cmd.wr_mode)
            WR_ENTRY:
            begin
                wr_addr = ptr_reg;
                wr_data = {1'b1, key_reg, val_reg};
            end
            WR_MOVE:
            begin
                wr_addr = gap_reg;
                wr_data = {1'b1, q_key, q_val};
            end
            default:
            begin
                wr_addr = ptr_reg;
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            q_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            n_reg     <= '0;
            gap_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (cmd.ptr_op)
                P_HOME:  ptr_reg <= mod_rem;
                P_NEXT:  ptr_reg <= ptr_step;
                default: ptr_reg <= ptr_reg;
            endcase
            case (cmd.n_op)
                N_ZERO:  n_reg <= '0;
                N_ONE:   n_reg <= AW'(1);
                N_INC:   n_reg <= n_reg + AW'(1);
                default: n_reg <= n_reg;
            endcase
            if (cmd.gap_load)
            begin
                gap_reg <= ptr_reg;
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.cnt_dec && (count_reg != '0))
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign val_ext = {{VAL_W{1'b0}}, q_val};
    assign cnt_ext = {{COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func_t'(req_func);
            key_reg  <= req_key[KW-1:0];
            val_reg  <= req_value[VW-1:0];
        end
        if (cmd.load_result)
        begin
            status_reg <= cmd.res_status;
            rdval_reg  <= (cmd.res_status == ST_HIT) ? val_ext[VAL_W-1:0] : '0;
            ecount_reg <= cnt_ext[COUNT_W-1:0];
            empty_reg  <= (count_reg == '0);
        end
    end

    assign sts.func      = func_reg;
    assign sts.mod_done  = mod_done;
    assign sts.row_used  = q_used;
    assign sts.key_match = (q_key == key_reg);
    assign sts.stays     = stays;
    assign sts.ptr_last  = ptr_last;
    assign sts.n_last    = (n_reg == AW'(CAPACITY - 1));

    assign rsp_status      = status_reg;
    assign rsp_read_value  = rdval_reg;
    assign rsp_entry_count = ecount_reg;
    assign rsp_is_empty    = empty_reg;

endmodule

### rtl/lphm_ctrl.sv
module lphm_ctrl import lphm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output lphm_cmd_t cmd,
    input  lphm_sts_t sts
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_HASH  = 12'b0000_0000_0100,
        S_HWAIT = 12'b0000_0000_1000,
        S_READ  = 12'b0000_0001_0000,
        S_CHECK = 12'b0000_0010_0000,
        S_DREAD = 12'b0000_0100_0000,
        S_DCHK  = 12'b0000_1000_0000,
        S_DHW   = 12'b0001_0000_0000,
        S_DMOVE = 12'b0010_0000_0000,
        S_DFREE = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;
    logic    out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = st_reg;
        state_next     = state_reg;
        st_next        = st_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_mode = WR_CLR_PTR;
                cmd.ptr_op  = P_NEXT;
                if (sts.ptr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                case (sts.func) inside
                    FN_SEARCH, FN_INSERT, FN_REMOVE:
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = S_HWAIT;
                    end
                    default:
                    begin
                        st_next    = ST_MISS;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_HWAIT:
            begin
                if (sts.mod_done)
                begin
                    cmd.ptr_op = P_HOME;
                    cmd.n_op   = N_ZERO;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!sts.row_used)
                begin
                    if (sts.func == FN_INSERT)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_mode = WR_ENTRY;
                        cmd.cnt_inc = 1'b1;
                        st_next     = ST_NEW;
                    end
                    else
                    begin
                        st_next = ST_MISS;
                    end
                    state_next = S_DONE;
                end
                else if (sts.key_match)
                begin
                    case (sts.func)
                        FN_SEARCH:
                        begin
                            st_next    = ST_HIT;
                            state_next = S_DONE;
                        end
                        FN_INSERT:
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_mode = WR_ENTRY;
                            st_next     = ST_UPD;
                            state_next  = S_DONE;
                        end
                        FN_REMOVE:
                        begin
                            // free the slot, then walk the chain behind it
                            cmd.wr_en    = 1'b1;
                            cmd.wr_mode  = WR_CLR_PTR;
                            cmd.gap_load = 1'b1;
                            cmd.ptr_op   = P_NEXT;
                            cmd.n_op     = N_ONE;
                            cmd.cnt_dec  = 1'b1;
                            st_next      = ST_REM;
                            state_next   = S_DREAD;
                        end
                        default:
                        begin
                            st_next    = ST_MISS;
                            state_next = S_DONE;
                        end
                    endcase
                end
                else if (sts.n_last)
                begin
                    st_next    = (sts.func == FN_INSERT) ? ST_FULL : ST_MISS;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ptr_op = P_NEXT;
                    cmd.n_op   = N_INC;
                    state_next = S_READ;
                end
            end
            S_DREAD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                if (!sts.row_used)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mod_start   = 1'b1;
                    cmd.mod_sel_row = 1'b1;
                    state_next      = S_DHW;
                end
            end
            S_DHW:
            begin
                if (sts.mod_done)
                begin
                    if (!sts.stays)
                    begin
                        state_next = S_DMOVE;
                    end
                    else if (sts.n_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_op = P_NEXT;
                        cmd.n_op   = N_INC;
                        state_next = S_DREAD;
                    end
                end
            end
            S_DMOVE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_mode = WR_MOVE;
                state_next  = S_DFREE;
            end
            S_DFREE:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_mode  = WR_CLR_PTR;
                cmd.gap_load = 1'b1;
                if (sts.n_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ptr_op = P_NEXT;
                    cmd.n_op   = N_INC;
                    state_next = S_DREAD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            st_reg        <= ST_MISS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/lphm_chk.sv
`include "linear_probe_hash_map_core_macros.svh"

module lphm_chk import lphm_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [2:0]         rsp_status,
    input logic [VAL_W-1:0]   rsp_read_value,
    input logic [COUNT_W-1:0] rsp_entry_count,
    input logic               rsp_is_empty
);

    `LPHM_ASSERT_NOW(a_count_not_empty, rsp_valid && (rsp_entry_count != '0), !rsp_is_empty, "nonzero entry count reported as empty")

    `LPHM_ASSERT_NOW(a_value_only_on_hit, rsp_valid && (rsp_status != ST_HIT), rsp_read_value == '0, "read value nonzero without a hit")

    `LPHM_ASSERT_NOW(a_insert_not_empty, rsp_valid && (rsp_status == ST_NEW), !rsp_is_empty, "new entry but table reported empty")

    `LPHM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_entry_count), "stalled result changed")

endmodule

bind linear_probe_hash_map_core lphm_chk u_lphm_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_read_value  (rsp.read_value),
    .rsp_entry_count (rsp.entry_count),
    .rsp_is_empty    (rsp.is_empty)
);
